// File: rtl/trdrf_pkg.sv
// ----------------------------------------------------------------------------
// trdrf_pkg
// Shared widths, register indexes and the result record of the text row
// dirty run finder.
// ----------------------------------------------------------------------------
package trdrf_pkg;

   localparam int CELL_W  = 16;
   localparam int COL_W   = 8;
   localparam int LEN_W   = 9;
   localparam int ATTR_W  = 8;
   localparam int TRAIL_W = 5;
   localparam int GAP_W   = 4;

   localparam logic [GAP_W-1:0] GAP_LIMIT_RESET = 4'd3;

   // APB port: one 32-bit register at byte address 0.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_GAP_LIMIT = 1'b0;

   // Result queue between the run logic and the response channel.
   localparam int RQ_DEPTH = 4;
   localparam int RQ_PTR_W = 2;
   localparam int RQ_CNT_W = 3;

   typedef struct packed {
      logic [COL_W-1:0]  start_col;
      logic [LEN_W-1:0]  run_length;
      logic [ATTR_W-1:0] run_attr;
      logic              last;
   } run_item_type;

endpackage

// File: rtl/trdrf_if.sv
// ----------------------------------------------------------------------------
// trdrf_if
// Valid/ready channels for cell requests and redraw run responses.
// ----------------------------------------------------------------------------
interface trdrf_req_if
   import trdrf_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CELL_W-1:0] new_cell;
   logic [CELL_W-1:0] old_cell;
   logic              last_in_line;

   modport source (output valid, new_cell, old_cell, last_in_line, input ready);
   modport sink   (input valid, new_cell, old_cell, last_in_line, output ready);
endinterface

interface trdrf_rsp_if
   import trdrf_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [COL_W-1:0]  start_col;
   logic [LEN_W-1:0]  run_length;
   logic [ATTR_W-1:0] run_attr;
   logic              last;

   modport source (output valid, start_col, run_length, run_attr, last, input ready);
   modport sink   (input valid, start_col, run_length, run_attr, last, output ready);
endinterface

// File: rtl/text_row_dirty_run_finder_unit.sv
// ----------------------------------------------------------------------------
// text_row_dirty_run_finder_unit
// Scans a text row one cell per request and reports the runs to redraw.
// ----------------------------------------------------------------------------
// A run closed by a cell is written into the result queue when that cell is
// accepted, and reaches the response channel once older runs have left.
// Throughput: one cell per cycle, with a four-entry result queue; a cell is
// taken only while at least two queue slots are free.
// Reset: synchronous; clears the run state, column and queue, gap_limit = 3.
module text_row_dirty_run_finder_unit
   import trdrf_pkg::*;
#(
   parameter int MAX_COLS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   trdrf_req_if.sink             req_ch,
   trdrf_rsp_if.source           rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_COLS - 1);

   // Configuration.
   logic [GAP_W-1:0] gap_limit_ff;
   logic             csr_wr;

   // Run state.
   logic               in_run_ff,   in_run_in;
   logic [COL_W-1:0]   run_start_ff, run_start_in;
   logic [ATTR_W-1:0]  run_attr_ff,  run_attr_in;
   logic [TRAIL_W-1:0] trail_ff,     trail_in;
   logic [COL_W-1:0]   column_ff,    column_in;

   // Result queue.
   run_item_type        rq_mem_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0] rq_wr_ff, rq_rd_ff;
   logic [RQ_CNT_W-1:0] rq_cnt_ff;

   logic               accept, pop;
   logic               changed, line_end, close_a, taken, open_run, close_b;
   logic [ATTR_W-1:0]  attr;
   logic               in_mid;
   logic [LEN_W-1:0]   len_a, len_b;
   logic [1:0]         n_res;
   run_item_type       res0, res1;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready & (paddr[2] == CSR_IDX_GAP_LIMIT);
   assign prdata = (paddr[2] == CSR_IDX_GAP_LIMIT) ?
                   {{(CSR_DATA_W-GAP_W){1'b0}}, gap_limit_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_limit_ff <= GAP_LIMIT_RESET;
      end else if (csr_wr) begin
         gap_limit_ff <= pwdata[GAP_W-1:0];
      end
   end

   assign req_ch.ready = (rq_cnt_ff <= RQ_CNT_W'(RQ_DEPTH - 2));
   assign accept = req_ch.valid & req_ch.ready;
   assign pop    = rsp_ch.valid & rsp_ch.ready;

   always_comb begin
      changed  = req_ch.new_cell != req_ch.old_cell;
      attr     = req_ch.new_cell[CELL_W-1:CELL_W-ATTR_W];
      // An overlong row ends at the last column so the counter never wraps.
      line_end = req_ch.last_in_line | (column_ff >= LAST_COL);

      // A different attribute, or one unchanged cell too many, closes the
      // open run without joining it.
      close_a  = in_run_ff & ((attr != run_attr_ff) |
                 (~changed & (trail_ff > {1'b0, gap_limit_ff})));
      taken    = in_run_ff & ~close_a;
      open_run = ~taken & changed;
      in_mid   = taken | open_run;

      run_start_in = run_start_ff;
      run_attr_in  = run_attr_ff;
      trail_in     = trail_ff;
      if (open_run) begin
         run_start_in = column_ff;
         run_attr_in  = attr;
         trail_in     = '0;
      end else if (taken) begin
         trail_in = changed ? '0 : trail_ff + TRAIL_W'(1);
      end

      close_b   = line_end & in_mid;
      in_run_in = in_mid & ~line_end;
      column_in = line_end ? '0 : column_ff + COL_W'(1);

      len_a = {1'b0, column_ff} - {1'b0, run_start_ff}
              - {{(LEN_W-TRAIL_W){1'b0}}, trail_ff};
      len_b = {1'b0, column_ff} + LEN_W'(1) - {1'b0, run_start_in}
              - {{(LEN_W-TRAIL_W){1'b0}}, trail_in};

      n_res = {1'b0, close_a} + {1'b0, close_b};

      res1.start_col  = run_start_in;
      res1.run_length = len_b;
      res1.run_attr   = run_attr_in;
      res1.last       = 1'b1;

      if (close_a) begin
         res0.start_col  = run_start_ff;
         res0.run_length = len_a;
         res0.run_attr   = run_attr_ff;
         res0.last       = ~close_b;
      end else begin
         res0 = res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff    <= 1'b0;
         run_start_ff <= '0;
         run_attr_ff  <= '0;
         trail_ff     <= '0;
         column_ff    <= '0;
      end else if (accept) begin
         in_run_ff    <= in_run_in;
         run_start_ff <= run_start_in;
         run_attr_ff  <= run_attr_in;
         trail_ff     <= trail_in;
         column_ff    <= column_in;
      end
   end

   // Result queue storage.
   always_ff @(posedge clock) begin
      if (accept && (n_res != 2'd0)) begin
         rq_mem_ff[rq_wr_ff] <= res0;
         if (n_res == 2'd2) begin
            rq_mem_ff[rq_wr_ff + RQ_PTR_W'(1)] <= res1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff  <= '0;
         rq_rd_ff  <= '0;
         rq_cnt_ff <= '0;
      end else begin
         if (accept) begin
            rq_wr_ff <= rq_wr_ff + RQ_PTR_W'(n_res);
         end
         if (pop) begin
            rq_rd_ff <= rq_rd_ff + RQ_PTR_W'(1);
         end
         rq_cnt_ff <= rq_cnt_ff + (accept ? RQ_CNT_W'(n_res) : '0)
                      - RQ_CNT_W'(pop);
      end
   end

   assign rsp_ch.valid      = (rq_cnt_ff != '0);
   assign rsp_ch.start_col  = rq_mem_ff[rq_rd_ff].start_col;
   assign rsp_ch.run_length = rq_mem_ff[rq_rd_ff].run_length;
   assign rsp_ch.run_attr   = rq_mem_ff[rq_rd_ff].run_attr;
   assign rsp_ch.last       = rq_mem_ff[rq_rd_ff].last;

   // The queue never holds more than its depth.
   a_rq_bound: assert property (@(posedge clock) disable iff (reset)
      rq_cnt_ff <= RQ_CNT_W'(RQ_DEPTH))
      else $error("result queue overflow");

   // A line end leaves the column at zero and no run open.
   a_line_end: assert property (@(posedge clock) disable iff (reset)
      accept && line_end |=> (column_ff == '0) && !in_run_ff)
      else $error("state not cleared at line end");

   // The tolerated gap is never exceeded by more than one cell.
   a_trail: assert property (@(posedge clock) disable iff (reset)
      in_run_ff |-> trail_ff <= {1'b0, gap_limit_ff} + TRAIL_W'(1) || $past(csr_wr))
      else $error("trailing unchanged count past gap limit");

   // Every request that closes runs marks its final result as last.
   a_last: assert property (@(posedge clock) disable iff (reset)
      accept && (n_res != 2'd0) |-> (n_res == 2'd2) ? !res0.last : res0.last)
      else $error("last flag misplaced");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text row dirty run finder. Cell requests go in
// with random gaps, and redraw runs are taken with random and long stalls.
// A local run tracker predicts every run, which is checked field by field in
// arrival order. The gap limit register is read back and rewritten between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
   import trdrf_pkg::*;

   localparam int MAX_COLS     = 256;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 80;
   localparam int SETTLE_CYCLES = 4;
   localparam logic [CSR_ADDR_W-1:0] GAP_LIMIT_ADDR = {CSR_IDX_GAP_LIMIT, 2'b00};

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   trdrf_req_if req_if ();
   trdrf_rsp_if rsp_if ();

   text_row_dirty_run_finder_unit #(
      .MAX_COLS (MAX_COLS)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Run tracker state
   logic [GAP_W-1:0]   gap_setting;
   logic               run_open;
   logic [COL_W-1:0]   run_first_col;
   logic [ATTR_W-1:0]  run_attr_byte;
   logic [TRAIL_W-1:0] unchanged_tail;
   logic [COL_W-1:0]   row_col;
   run_item_type       expected_runs[$];

   int  error_count = 0;
   int  cells_sent = 0;
   bit  idle_on = 1'b1;
   int  holds_asked = 0;
   int  holds_served = 0;
   int  hold_left = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void check_field(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
         error_count++;
      end
   endfunction

   function automatic void predict_runs(input logic [CELL_W-1:0] new_word,
                                        input logic [CELL_W-1:0] old_word,
                                        input logic eol);
      run_item_type      closed[2];
      int                found;
      logic              row_ends;
      logic              differs;
      logic              joined;
      logic [ATTR_W-1:0] attr;
      logic [LEN_W-1:0]  span;
      found = 0;
      joined = 1'b0;
      row_ends = eol || (int'(row_col) >= MAX_COLS - 1);
      differs = new_word != old_word;
      attr = new_word[CELL_W-1:8];
      span = {1'b0, row_col} - {1'b0, run_first_col} - {4'b0, unchanged_tail};
      if (run_open) begin
         // The closing cell is not part of the run it ends.
         if (attr != run_attr_byte || (!differs && unchanged_tail > {1'b0, gap_setting})) begin
            closed[found] = '{start_col: run_first_col, run_length: span,
                              run_attr: run_attr_byte, last: 1'b0};
            found++;
            run_open = 1'b0;
         end else begin
            unchanged_tail = differs ? '0 : unchanged_tail + 1'b1;
            joined = 1'b1;
         end
      end
      if (!joined && differs) begin
         run_open = 1'b1;
         run_first_col = row_col;
         run_attr_byte = attr;
         unchanged_tail = '0;
      end
      if (row_ends && run_open) begin
         span = {1'b0, row_col} + 9'd1 - {1'b0, run_first_col} - {4'b0, unchanged_tail};
         closed[found] = '{start_col: run_first_col, run_length: span,
                           run_attr: run_attr_byte, last: 1'b0};
         found++;
         run_open = 1'b0;
      end
      row_col = row_ends ? '0 : row_col + 1'b1;
      for (int i = 0; i < found; i++) begin
         closed[i].last = (i == found - 1);
         expected_runs.push_back(closed[i]);
      end
   endfunction

   task automatic send_cell(input logic [CELL_W-1:0] new_word,
                            input logic [CELL_W-1:0] old_word, input logic eol);
      if (idle_on) begin
         while ($urandom_range(99) < 26) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_if.valid        <= 1'b1;
      req_if.new_cell     <= new_word;
      req_if.old_cell     <= old_word;
      req_if.last_in_line <= eol;
      do @(posedge clock); while (!req_if.ready);
      predict_runs(new_word, old_word, eol);
      cells_sent++;
   endtask

   // Leaves the block idle: no request offered, no run outstanding.
   task automatic settle();
      req_if.valid <= 1'b0;
      while (expected_runs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apb_access(input logic write_en, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write_en;
      paddr   <= GAP_LIMIT_ADDR;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Reads back the current gap limit, then writes the new one.
   task automatic set_gap_limit(input logic [GAP_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      settle();
      apb_access(1'b0, '0, readback);
      check_field("gap_limit readback", {28'b0, gap_setting}, readback);
      apb_access(1'b1, {28'b0, value}, readback);
      gap_setting = value;
   endtask

   task automatic send_random_row(input int row_len);
      logic [ATTR_W-1:0] attr_a;
      logic [ATTR_W-1:0] attr_b;
      logic [ATTR_W-1:0] attr;
      logic [CELL_W-1:0] new_word;
      logic [CELL_W-1:0] old_word;
      int                changed_pct;
      int                pick;
      attr_a = 8'($urandom);
      attr_b = 8'($urandom);
      attr = attr_a;
      changed_pct = $urandom_range(15, 70);
      for (int i = 0; i < row_len; i++) begin
         if ($urandom_range(99) < 12) begin
            attr = ($urandom_range(1) != 0) ? attr_a : attr_b;
         end
         pick = $urandom_range(99);
         new_word = {attr, 8'($urandom)};
         if (pick < changed_pct) begin
            old_word = new_word ^ 16'($urandom_range(1, 65535));
         end else if (pick < 90) begin
            old_word = new_word;
         end else begin
            new_word = 16'($urandom);
            old_word = 16'($urandom);
         end
         // A stray line end now and then breaks a row early.
         send_cell(new_word, old_word, (i == row_len - 1) || ($urandom_range(99) < 2));
      end
   endtask

   task automatic send_random_cells(input int count);
      int first;
      int row_len;
      first = cells_sent;
      while (cells_sent - first < count) begin
         if ($urandom_range(7) == 0) begin
            row_len = $urandom_range(31, 80);
         end else begin
            row_len = $urandom_range(1, 30);
         end
         // The final row is cut short so the phase sends exactly its count.
         if (row_len > count - (cells_sent - first)) begin
            row_len = count - (cells_sent - first);
         end
         send_random_row(row_len);
      end
   endtask

   task automatic test_directed_rows();
      set_gap_limit(GAP_LIMIT_RESET);
      // Run opens, tolerates a gap, then one unchanged cell too many closes it.
      send_cell(16'h0741, 16'h0720, 1'b0);
      send_cell(16'h0720, 16'h0720, 1'b0);
      send_cell(16'h0720, 16'h0720, 1'b0);
      send_cell(16'h0742, 16'h0000, 1'b0);
      repeat (4) send_cell(16'h0720, 16'h0720, 1'b0);
      send_cell(16'h0720, 16'h0720, 1'b0);
      // Unchanged cell outside any run gives nothing.
      send_cell(16'hFFFF, 16'hFFFF, 1'b0);
      send_cell(16'hFFFF, 16'h0000, 1'b0);
      // Attribute change closes one run and opens another.
      send_cell(16'h00FF, 16'hFFFF, 1'b0);
      // Closing cell that opens a run and ends the line gives two runs.
      send_cell(16'h1E41, 16'h0041, 1'b1);
      send_cell(16'h0000, 16'h0000, 1'b0);
      send_cell(16'h0000, 16'h0001, 1'b1);
      send_cell(16'hABCD, 16'h1234, 1'b1);
      // Line ends on an unchanged cell inside a run.
      send_cell(16'h2041, 16'h2000, 1'b0);
      send_cell(16'h2020, 16'h2020, 1'b1);
      // Unchanged cell with another attribute closes the run and opens none.
      send_cell(16'h3031, 16'h3030, 1'b0);
      send_cell(16'h4040, 16'h4040, 1'b0);
      send_cell(16'h5555, 16'h5555, 1'b1);
   endtask

   // No line end is given; the last column must end the row by itself.
   task automatic test_overlong_row();
      logic [CELL_W-1:0] new_word;
      settle();
      for (int col = 0; col < MAX_COLS; col++) begin
         new_word = {8'h42, 8'(col)};
         send_cell(new_word, ~new_word, 1'b0);
      end
   endtask

   task automatic test_random_rows();
      set_gap_limit('0);
      send_random_cells(25);
      set_gap_limit('1);
      send_random_cells(25);
      repeat (2) begin
         set_gap_limit(GAP_W'($urandom_range(1, 14)));
         send_random_cells(20);
      end
   endtask

   // Every cell flips the attribute, so each one after the first in a row closes a run, and many end a line.
   task automatic test_output_stall();
      logic [CELL_W-1:0] new_word;
      holds_asked++;
      for (int i = 0; i < 45; i++) begin
         new_word = {(i % 2 == 0) ? 8'h5A : 8'hA5, 8'($urandom)};
         send_cell(new_word, ~new_word, $urandom_range(3) == 0);
      end
   endtask

   task automatic test_steady_stream();
      set_gap_limit(GAP_LIMIT_RESET);
      idle_on = 1'b0;
      send_random_cells(40);
      settle();
      idle_on = 1'b1;
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         rsp_if.ready <= 1'b0;
         holds_served <= holds_served + 1;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_if.ready <= !idle_on || ($urandom_range(99) >= 26);
      end
   end

   always @(posedge clock) begin
      run_item_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_runs.size() == 0) begin
            $display("%0t: unexpected run: expected none, actual start_col %0d length %0d",
                     $time, rsp_if.start_col, rsp_if.run_length);
            error_count++;
         end else begin
            want = expected_runs.pop_front();
            check_field("start_col", 32'(want.start_col), 32'(rsp_if.start_col));
            check_field("run_length", 32'(want.run_length), 32'(rsp_if.run_length));
            check_field("run_attr", 32'(want.run_attr), 32'(rsp_if.run_attr));
            check_field("last", 32'(want.last), 32'(rsp_if.last));
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t: no progress, %0d runs still expected", $time, expected_runs.size());
      $display("text_row_dirty_run_finder_unit verification failed");
      $finish;
   end

   initial begin
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.new_cell     <= '0;
      req_if.old_cell     <= '0;
      req_if.last_in_line <= 1'b0;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      gap_setting    = GAP_LIMIT_RESET;
      run_open       = 1'b0;
      run_first_col  = '0;
      run_attr_byte  = '0;
      unchanged_tail = '0;
      row_col        = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed_rows();
      test_overlong_row();
      test_random_rows();
      test_output_stall();
      test_steady_stream();
      settle();

      if (error_count == 0 && expected_runs.size() == 0) begin
         $display("text_row_dirty_run_finder_unit verification clean");
      end else begin
         $display("text_row_dirty_run_finder_unit verification failed");
      end
      $finish;
   end

endmodule
